FILE: hw/rtl/hvd_pkg.sv
package hvd_pkg;

   localparam int NUM_STATES  = 16;
   localparam int NUM_SYMBOLS = 16;
   localparam int NUM_STEPS   = 64;
   localparam int PROB_W      = 16;
   localparam int SCORE_W     = 2 * PROB_W;
   localparam int STATE_W     = 4;
   localparam int SYMBOL_W    = 4;
   localparam int COUNT_W     = 5;
   localparam int STEP_W      = 6;

   // request opcodes; the reserved codes are accepted and ignored
   typedef enum logic [2:0] {
      OP_LOAD_TRANS = 3'd0,
      OP_LOAD_EMIS  = 3'd1,
      OP_LOAD_INIT  = 3'd2,
      OP_OBSERVE    = 3'd3,
      OP_TRACEBACK  = 3'd4,
      OP_RESERVED_5 = 3'd5,
      OP_RESERVED_6 = 3'd6,
      OP_RESERVED_7 = 3'd7
   } opcode_type;

   // configuration register indexes
   localparam logic CSR_STATE_COUNT  = 1'b0;
   localparam logic CSR_SYMBOL_COUNT = 1'b1;

   // control bundle broadcast from the sequencer to every cell
   typedef struct packed {
      logic                  wr_trans;
      logic                  wr_emis;
      logic                  wr_init;
      logic [STATE_W-1:0]    wr_row;
      logic [STATE_W-1:0]    wr_col;
      logic [PROB_W-1:0]     wr_data;
      logic [COUNT_W-1:0]    n_act;
      logic [SYMBOL_W-1:0]   sym;
      logic                  sym_ok;
      logic                  ring_load;
      logic                  ring_shift;
      logic                  acs_clear;
      logic                  acs_mul;
      logic [STATE_W-1:0]    step;
      logic                  seed;
      logic                  finish;
      logic                  norm_shift;
   } ctrl_type;

endpackage

FILE: hw/rtl/hvd_cell.sv
module hvd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hvd_pkg::STATE_W-1:0]   cell_id,
   input  hvd_pkg::ctrl_type             ctrl,
   input  logic [hvd_pkg::SCORE_W-1:0]   ring_in,
   output logic [hvd_pkg::SCORE_W-1:0]   ring_out,
   output logic [hvd_pkg::STATE_W-1:0]   bp_out
);
   import hvd_pkg::*;

   // tables owned by this destination state
   logic [PROB_W-1:0] trans_mem [NUM_STATES];
   logic [PROB_W-1:0] emis_mem  [NUM_SYMBOLS];
   logic [PROB_W-1:0] init_ff;

   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] ring_ff;
   logic [SCORE_W-1:0] cand_ff;
   logic [STATE_W-1:0] cand_j_ff;
   logic               cand_vld_ff;
   logic [SCORE_W-1:0] best_ff;
   logic [STATE_W-1:0] bi_ff;
   logic [STATE_W-1:0] bp_ff;

   logic                      cell_act;
   logic [STATE_W-1:0]        pred;
   logic                      pred_act;
   logic [PROB_W-1:0]         emis_val;
   logic [SCORE_W+PROB_W-1:0] cand_prod;
   logic [SCORE_W-1:0]        seed_prod;
   logic [SCORE_W+PROB_W-1:0] fin_prod;
   logic                      take;

   assign cell_act  = {1'b0, cell_id} < ctrl.n_act;
   assign pred      = cell_id + ctrl.step;
   assign pred_act  = {1'b0, pred} < ctrl.n_act;
   assign emis_val  = ctrl.sym_ok ? emis_mem[ctrl.sym] : '0;
   assign cand_prod = ring_ff * trans_mem[pred];
   assign seed_prod = init_ff * emis_val;
   assign fin_prod  = best_ff * emis_val;

   // strict greater wins; among equal nonzero maxima the lowest index wins
   assign take = cand_vld_ff &&
                 ((cand_ff > best_ff) ||
                  (cand_ff == best_ff && cand_ff != '0 && cand_j_ff < bi_ff));

   // table loads
   always_ff @(posedge clock) begin
      if (ctrl.wr_trans && ctrl.wr_col == cell_id) begin
         trans_mem[ctrl.wr_row] <= ctrl.wr_data;
      end
      if (ctrl.wr_emis && ctrl.wr_row == cell_id) begin
         emis_mem[ctrl.wr_col] <= ctrl.wr_data;
      end
      if (ctrl.wr_init && ctrl.wr_row == cell_id) begin
         init_ff <= ctrl.wr_data;
      end
   end

   // ring stage and candidate multiply
   always_ff @(posedge clock) begin
      if (ctrl.ring_load) begin
         ring_ff <= score_ff;
      end else if (ctrl.ring_shift) begin
         ring_ff <= ring_in;
      end
      cand_ff   <= cand_prod[SCORE_W+PROB_W-1:PROB_W];
      cand_j_ff <= pred;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_vld_ff <= 1'b0;
      end else begin
         cand_vld_ff <= ctrl.acs_mul && pred_act;
      end
   end

   // compare-select
   always_ff @(posedge clock) begin
      if (ctrl.acs_clear) begin
         best_ff <= '0;
         bi_ff   <= '0;
      end else if (take) begin
         best_ff <= cand_ff;
         bi_ff   <= cand_j_ff;
      end
   end

   // path score update
   always_ff @(posedge clock) begin
      if (ctrl.seed) begin
         score_ff <= cell_act ? seed_prod : '0;
         bp_ff    <= '0;
      end else if (ctrl.finish) begin
         score_ff <= cell_act ? fin_prod[SCORE_W+PROB_W-1:PROB_W] : '0;
         bp_ff    <= cell_act ? bi_ff : '0;
      end else if (ctrl.norm_shift) begin
         score_ff <= {score_ff[SCORE_W-2:0], 1'b0};
      end
   end

   assign ring_out = ring_ff;
   assign bp_out   = bp_ff;

endmodule

FILE: hw/rtl/hmm_viterbi_decoder.sv
// Channel   Ports                         Transfer
// request   start, busy, req_*            start high and busy low at a clock edge
// result    rsp_valid, rsp_*              rsp_valid high for one cycle, always taken
// csr       csr_write, csr_index, csr_*   csr_write high at a clock edge
//
// Loads never raise busy.
// Observe: the ring of 16 add-compare-select cells makes one sweep for the
// predecessors (not for the first step, which is seeded instead), one for the
// maximum, then up to 31 one-bit left shifts and a closing step.
// Traceback of T steps: a sweep for the best final state, backtracking, then
// the results in time order, each via a registered read of the sequence buffer.
// Reset is synchronous; results cannot be stalled.
module hmm_viterbi_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_opcode,
   input  logic [hvd_pkg::STATE_W-1:0]    req_row_index,
   input  logic [hvd_pkg::STATE_W-1:0]    req_col_index,
   input  logic [hvd_pkg::PROB_W-1:0]     req_prob_value,
   input  logic [hvd_pkg::SYMBOL_W-1:0]   req_symbol,
   output logic                           rsp_valid,
   output logic [hvd_pkg::STATE_W-1:0]    rsp_state_index,
   output logic [hvd_pkg::STEP_W-1:0]     rsp_time_index,
   output logic                           rsp_last,
   output logic                           rsp_overflow,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [hvd_pkg::COUNT_W-1:0]    csr_wdata
);
   import hvd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_ACS_LOAD,
      ST_ACS_RUN,
      ST_ACS_DRAIN,
      ST_ACS_DONE,
      ST_SCAN_LOAD,
      ST_SCAN_RUN,
      ST_NORM,
      ST_TB_START,
      ST_TB_READ,
      ST_TB_STEP,
      ST_OUT_READ,
      ST_OUT_EMIT
   } state_type;

   state_type             state_ff;
   logic [COUNT_W-1:0]    state_count_ff;
   logic [COUNT_W-1:0]    symbol_count_ff;
   logic [STEP_W:0]       step_count_ff;
   logic                  overflow_ff;
   logic [SYMBOL_W-1:0]   sym_ff;
   logic                  tb_mode_ff;
   logic [STATE_W-1:0]    k_ff;
   logic [SCORE_W-1:0]    max_ff;
   logic [SCORE_W-1:0]    arg_best_ff;
   logic [STATE_W-1:0]    idx_ff;
   logic [STEP_W-1:0]     t_ff;
   logic [STEP_W-1:0]     o_ff;
   logic                  rsp_valid_ff;
   logic [STATE_W-1:0]    rsp_state_ff;
   logic [STEP_W-1:0]     rsp_time_ff;
   logic                  rsp_last_ff;
   logic                  rsp_overflow_ff;

   logic [NUM_STATES*STATE_W-1:0] bp_mem [NUM_STEPS];
   logic [NUM_STATES*STATE_W-1:0] bp_rd_ff;
   logic [STATE_W-1:0]            seq_mem [NUM_STEPS];
   logic [STATE_W-1:0]            seq_rd_ff;

   logic [SCORE_W-1:0]            ring_bus [NUM_STATES];
   logic [STATE_W-1:0]            bp_bus   [NUM_STATES];
   logic [NUM_STATES*STATE_W-1:0] bp_row;

   ctrl_type              ctrl;
   logic                  accept;
   logic [COUNT_W-1:0]    n_act;
   logic [COUNT_W-1:0]    n_sym;
   logic [SCORE_W-1:0]    scan_val;
   logic                  norm_go;
   logic [STATE_W-1:0]    next_idx;
   logic [STEP_W-1:0]     last_step;
   logic                  seq_we;
   logic [STEP_W-1:0]     seq_waddr;
   logic [STATE_W-1:0]    seq_wdata;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   // active counts, saturated to the supported range
   assign n_act = (state_count_ff == '0) ? COUNT_W'(1) :
                  (state_count_ff > COUNT_W'(NUM_STATES)) ? COUNT_W'(NUM_STATES) :
                  state_count_ff;
   assign n_sym = (symbol_count_ff == '0) ? COUNT_W'(1) :
                  (symbol_count_ff > COUNT_W'(NUM_SYMBOLS)) ? COUNT_W'(NUM_SYMBOLS) :
                  symbol_count_ff;

   assign scan_val  = ring_bus[0];
   assign norm_go   = (max_ff != '0) && !max_ff[SCORE_W-1];
   assign next_idx  = bp_rd_ff[idx_ff*STATE_W +: STATE_W];
   assign last_step = STEP_W'(step_count_ff - 1'b1);

   // cell control decode
   always_comb begin
      ctrl            = '0;
      ctrl.wr_trans   = accept && req_opcode == OP_LOAD_TRANS;
      ctrl.wr_emis    = accept && req_opcode == OP_LOAD_EMIS;
      ctrl.wr_init    = accept && req_opcode == OP_LOAD_INIT;
      ctrl.wr_row     = req_row_index;
      ctrl.wr_col     = req_col_index;
      ctrl.wr_data    = req_prob_value;
      ctrl.n_act      = n_act;
      ctrl.sym        = sym_ff;
      ctrl.sym_ok     = {1'b0, sym_ff} < n_sym;
      ctrl.step       = k_ff;
      ctrl.ring_load  = state_ff == ST_ACS_LOAD || state_ff == ST_SCAN_LOAD;
      ctrl.ring_shift = state_ff == ST_ACS_RUN || state_ff == ST_SCAN_RUN;
      ctrl.acs_clear  = state_ff == ST_ACS_LOAD;
      ctrl.acs_mul    = state_ff == ST_ACS_RUN;
      ctrl.seed       = state_ff == ST_SEED;
      ctrl.finish     = state_ff == ST_ACS_DONE;
      ctrl.norm_shift = state_ff == ST_NORM && norm_go;
   end

   // ring of cells, each passing its score to the cell below
   for (genvar gi = 0; gi < NUM_STATES; gi++) begin : g_cell
      hvd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (STATE_W'(gi)),
         .ctrl     (ctrl),
         .ring_in  (ring_bus[(gi + 1) % NUM_STATES]),
         .ring_out (ring_bus[gi]),
         .bp_out   (bp_bus[gi])
      );
      assign bp_row[gi*STATE_W +: STATE_W] = bp_bus[gi];
   end

   // backpointer memory, one row per time step
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN_LOAD && !tb_mode_ff) begin
         bp_mem[step_count_ff[STEP_W-1:0]] <= bp_row;
      end
      if (state_ff == ST_TB_READ) begin
         bp_rd_ff <= bp_mem[t_ff];
      end
   end

   // decoded sequence buffer
   always_comb begin
      seq_we    = 1'b0;
      seq_waddr = t_ff - 1'b1;
      seq_wdata = next_idx;
      case (state_ff)
         ST_TB_START: begin
            seq_we    = 1'b1;
            seq_waddr = last_step;
            seq_wdata = idx_ff;
         end
         ST_TB_STEP: begin
            seq_we = 1'b1;
         end
         default: begin
            seq_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_waddr] <= seq_wdata;
      end
      if (state_ff == ST_OUT_READ) begin
         seq_rd_ff <= seq_mem[o_ff];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= COUNT_W'(16);
         symbol_count_ff <= COUNT_W'(16);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STATE_COUNT:  state_count_ff  <= csr_wdata;
            CSR_SYMBOL_COUNT: symbol_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_count_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tb_mode_ff    <= 1'b0;
         k_ff          <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sym_ff <= req_symbol;
                  case (req_opcode)
                     OP_OBSERVE: begin
                        tb_mode_ff <= 1'b0;
                        if (step_count_ff == (STEP_W+1)'(NUM_STEPS)) begin
                           overflow_ff <= 1'b1;
                        end else if (step_count_ff == '0) begin
                           state_ff <= ST_SEED;
                        end else begin
                           state_ff <= ST_ACS_LOAD;
                        end
                     end
                     OP_TRACEBACK: begin
                        tb_mode_ff <= 1'b1;
                        if (step_count_ff != '0) begin
                           state_ff <= ST_SCAN_LOAD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SEED: begin
               state_ff <= ST_SCAN_LOAD;
            end
            ST_ACS_LOAD: begin
               k_ff     <= '0;
               state_ff <= ST_ACS_RUN;
            end
            ST_ACS_RUN: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == STATE_W'(NUM_STATES - 1)) begin
                  state_ff <= ST_ACS_DRAIN;
               end
            end
            ST_ACS_DRAIN: begin
               state_ff <= ST_ACS_DONE;
            end
            ST_ACS_DONE: begin
               state_ff <= ST_SCAN_LOAD;
            end
            ST_SCAN_LOAD: begin
               k_ff        <= '0;
               max_ff      <= '0;
               arg_best_ff <= '0;
               idx_ff      <= '0;
               state_ff    <= ST_SCAN_RUN;
            end
            ST_SCAN_RUN: begin
               // cell 0 sees state k in turn
               if (scan_val > max_ff) begin
                  max_ff <= scan_val;
               end
               if ({1'b0, k_ff} < n_act && scan_val > arg_best_ff) begin
                  arg_best_ff <= scan_val;
                  idx_ff      <= k_ff;
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == STATE_W'(NUM_STATES - 1)) begin
                  state_ff <= tb_mode_ff ? ST_TB_START : ST_NORM;
               end
            end
            ST_NORM: begin
               if (norm_go) begin
                  max_ff <= {max_ff[SCORE_W-2:0], 1'b0};
               end else begin
                  step_count_ff <= step_count_ff + 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_TB_START: begin
               t_ff <= last_step;
               o_ff <= '0;
               state_ff <= (last_step == '0) ? ST_OUT_READ : ST_TB_READ;
            end
            ST_TB_READ: begin
               state_ff <= ST_TB_STEP;
            end
            ST_TB_STEP: begin
               idx_ff <= next_idx;
               t_ff   <= t_ff - 1'b1;
               state_ff <= (t_ff == STEP_W'(1)) ? ST_OUT_READ : ST_TB_READ;
            end
            ST_OUT_READ: begin
               state_ff <= ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_state_ff    <= seq_rd_ff;
               rsp_time_ff     <= o_ff;
               rsp_last_ff     <= o_ff == last_step;
               rsp_overflow_ff <= overflow_ff;
               if (o_ff == last_step) begin
                  step_count_ff <= '0;
                  overflow_ff   <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else begin
                  o_ff     <= o_ff + 1'b1;
                  state_ff <= ST_OUT_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_state_index = rsp_state_ff;
   assign rsp_time_index  = rsp_time_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   // checks
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_count_ff <= (STEP_W+1)'(NUM_STEPS))
      else $error("step count beyond capacity");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a running traceback");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> step_count_ff == '0 && !busy)
      else $error("final result did not end the run");

   a_overflow_set: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == OP_OBSERVE && step_count_ff == (STEP_W+1)'(NUM_STEPS)
      |=> overflow_ff && !busy)
      else $error("dropped observation not flagged");

endmodule
